@@ rtl/stxrx_pkg.sv @@
// ----------------------------------------------------------------------------
// stxrx_pkg
// Shared types and constants for the STX/ETX frame receiver with XOR BCC.
// ----------------------------------------------------------------------------
package stxrx_pkg;

    localparam int MAX_PAYLOAD_LEN_DEF = 255;
    localparam int COUNT_W             = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // ASCII control characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ENQ = 8'h05;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_DC3 = 8'h13;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_SYN = 8'h16;

    typedef enum logic [3:0] {
        K_NONE       = 4'd0,
        K_PAYLOAD    = 4'd1,
        K_GOOD       = 4'd2,
        K_BADSUM     = 4'd3,
        K_UNREADABLE = 4'd4,
        K_STRAY      = 4'd5,
        K_ENQ        = 4'd6,
        K_ACK        = 4'd7,
        K_NAK        = 4'd8,
        K_SYN        = 4'd9,
        K_DC3        = 4'd10,
        K_EOT        = 4'd11
    } kind_t;

    typedef enum logic [1:0] {
        PH_WAIT_STX = 2'd0,
        PH_PAYLOAD  = 2'd1,
        PH_SUM_HI   = 2'd2,
        PH_SUM_LO   = 2'd3
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic       too_long;
    } result_t;

endpackage

@@ rtl/stxrx_frame.sv @@
// ----------------------------------------------------------------------------
// stxrx_frame
// Frame state (phase, running XOR, first check char, payload count) and the
// per-beat decode that yields one result for each received byte.
// ----------------------------------------------------------------------------
module stxrx_frame #(
    parameter int MAX_PAYLOAD_LEN = stxrx_pkg::MAX_PAYLOAD_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output stxrx_pkg::result_t  result
);

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end
        else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic over_limit(input logic [stxrx_pkg::COUNT_W-1:0] cnt);
        return 32'(cnt) > 32'(MAX_PAYLOAD_LEN);
    endfunction

    stxrx_pkg::phase_t              phase_reg, phase_next;
    logic [7:0]                     xor_reg, xor_next;
    logic [7:0]                     first_reg, first_next;
    logic [stxrx_pkg::COUNT_W-1:0]  count_reg, count_next;

    hex_t       hi_dec, lo_dec;
    logic       is_ctrl;

    assign hi_dec = hex_decode(first_reg);
    assign lo_dec = hex_decode(rx_byte);

    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        first_next = first_reg;
        count_next = count_reg;

        result              = '0;
        result.kind         = stxrx_pkg::K_NONE;
        is_ctrl             = 1'b1;

        // control bytes bypass the frame machine
        unique case (rx_byte)
            stxrx_pkg::CH_ENQ:
            begin
                result.kind        = stxrx_pkg::K_ENQ;
                result.reply_valid = 1'b1;
                result.reply_byte  = stxrx_pkg::CH_SYN;
            end
            stxrx_pkg::CH_ACK: result.kind = stxrx_pkg::K_ACK;
            stxrx_pkg::CH_NAK: result.kind = stxrx_pkg::K_NAK;
            stxrx_pkg::CH_SYN: result.kind = stxrx_pkg::K_SYN;
            stxrx_pkg::CH_DC3: result.kind = stxrx_pkg::K_DC3;
            stxrx_pkg::CH_EOT: result.kind = stxrx_pkg::K_EOT;
            default:           is_ctrl     = 1'b0;
        endcase

        if (!is_ctrl) begin
            unique case (phase_reg)
                stxrx_pkg::PH_WAIT_STX:
                begin
                    if (rx_byte == stxrx_pkg::CH_STX) begin
                        phase_next = stxrx_pkg::PH_PAYLOAD;
                        xor_next   = 8'h00;
                        first_next = 8'h00;
                        count_next = '0;
                    end
                    else begin
                        result.kind = stxrx_pkg::K_STRAY;
                    end
                end
                stxrx_pkg::PH_PAYLOAD:
                begin
                    xor_next = xor_reg ^ rx_byte;
                    if (rx_byte == stxrx_pkg::CH_ETX) begin
                        phase_next = stxrx_pkg::PH_SUM_HI;
                    end
                    else begin
                        result.kind         = stxrx_pkg::K_PAYLOAD;
                        result.payload_byte = rx_byte;
                        if (count_reg != stxrx_pkg::COUNT_MAX) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                stxrx_pkg::PH_SUM_HI:
                begin
                    first_next = rx_byte;
                    phase_next = stxrx_pkg::PH_SUM_LO;
                end
                stxrx_pkg::PH_SUM_LO:
                begin
                    if (!hi_dec.ok || !lo_dec.ok) begin
                        result.kind = stxrx_pkg::K_UNREADABLE;
                    end
                    else if ({hi_dec.val, lo_dec.val} == xor_reg) begin
                        result.kind        = stxrx_pkg::K_GOOD;
                        result.reply_valid = 1'b1;
                        result.reply_byte  = stxrx_pkg::CH_ACK;
                    end
                    else begin
                        result.kind        = stxrx_pkg::K_BADSUM;
                        result.reply_valid = 1'b1;
                        result.reply_byte  = stxrx_pkg::CH_NAK;
                    end
                    phase_next = stxrx_pkg::PH_WAIT_STX;
                    count_next = '0;
                end
                default: ;
            endcase
        end

        // closing check char still reports the finished frame's length
        if (!is_ctrl && phase_reg == stxrx_pkg::PH_SUM_LO) begin
            result.too_long = over_limit(count_reg);
        end
        else begin
            result.too_long = over_limit(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= stxrx_pkg::PH_WAIT_STX;
            xor_reg   <= 8'h00;
            first_reg <= 8'h00;
            count_reg <= '0;
        end
        else if (step) begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            first_reg <= first_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/stx_etx_frame_receiver_xor_bcc.sv @@
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver_xor_bcc
// STX/ETX frame receiver with XOR block check in ASCII hex.
// ----------------------------------------------------------------------------
// One received serial byte enters per beat on the input channel
// (in_valid / in_stall / rx_byte). Each byte yields exactly one result beat
// on the output channel (out_valid / out_stall and the result fields):
// kind, payload_byte, reply_valid, reply_byte and too_long.
// The path is an input register, the frame decode, and a result register:
// out_valid rises once a byte has passed from the input register into the
// result register; an output stall can hold that move back. One byte per cycle is
// sustained while the output is not stalled. Frame state is updated as
// a byte passes from the input register into the result register.
// When the output is stalled the result register holds, the input register
// holds its byte, and in_stall rises only once the input register is full,
// so nothing is lost or repeated. Reset empties both registers and returns
// the frame machine to waiting for STX with check, first check char and
// payload count cleared.
// ----------------------------------------------------------------------------
module stx_etx_frame_receiver_xor_bcc #(
    parameter int MAX_PAYLOAD_LEN = stxrx_pkg::MAX_PAYLOAD_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  kind,
    output logic [7:0]  payload_byte,
    output logic        reply_valid,
    output logic [7:0]  reply_byte,
    output logic        too_long
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    stxrx_pkg::result_t res_reg;
    stxrx_pkg::result_t res_next;
    logic               advance;
    logic               step;

    // result register free or being taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    stxrx_frame #(
        .MAX_PAYLOAD_LEN (MAX_PAYLOAD_LEN)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (!in_stall) begin
                in_valid_reg <= in_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            in_byte_reg <= rx_byte;
        end
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = res_reg.kind;
    assign payload_byte = res_reg.payload_byte;
    assign reply_valid  = res_reg.reply_valid;
    assign reply_byte   = res_reg.reply_byte;
    assign too_long     = res_reg.too_long;

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the STX/ETX frame receiver with XOR BCC.
// A directed table covers control bytes, stray bytes, payload extremes and
// each check outcome. Random traffic follows: mostly well-formed frames with
// random content and checks, plus noise, interleaved control bytes and long
// frames. Every result beat is compared against its table row or an in-bench decoder.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stxrx_pkg::*;

    localparam int PAYLOAD_LIMIT = MAX_PAYLOAD_LEN_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_AFTER    = 100;
    localparam int HOLD_CYCLES   = 80;
    localparam int TAIL_CYCLES   = 8;

    localparam logic [7:0] CONTROL_BYTES [6] =
        '{CH_ENQ, CH_ACK, CH_NAK, CH_SYN, CH_DC3, CH_EOT};

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        result_t    want;
    } directed_row_t;

    localparam int N_DIRECTED = 24;
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h41,  1'b1, '{K_STRAY,      8'h00, 1'b0, 8'h00,  1'b0}},
        '{8'hFF,  1'b1, '{K_STRAY,      8'h00, 1'b0, 8'h00,  1'b0}},
        '{CH_ENQ, 1'b1, '{K_ENQ,        8'h00, 1'b1, CH_SYN, 1'b0}},
        '{CH_ACK, 1'b1, '{K_ACK,        8'h00, 1'b0, 8'h00,  1'b0}},
        '{CH_NAK, 1'b1, '{K_NAK,        8'h00, 1'b0, 8'h00,  1'b0}},
        '{CH_SYN, 1'b1, '{K_SYN,        8'h00, 1'b0, 8'h00,  1'b0}},
        '{CH_DC3, 1'b1, '{K_DC3,        8'h00, 1'b0, 8'h00,  1'b0}},
        '{CH_EOT, 1'b1, '{K_EOT,        8'h00, 1'b0, 8'h00,  1'b0}},
        '{CH_STX, 1'b1, '{K_NONE,       8'h00, 1'b0, 8'h00,  1'b0}},
        '{8'h00,  1'b1, '{K_PAYLOAD,    8'h00, 1'b0, 8'h00,  1'b0}},
        '{8'hFF,  1'b1, '{K_PAYLOAD,    8'hFF, 1'b0, 8'h00,  1'b0}},
        // STX inside a frame is plain payload
        '{CH_STX, 1'b0, '0},
        '{CH_ENQ, 1'b0, '0},
        '{CH_ETX, 1'b0, '0},
        // check FE, mixed case
        '{8'h46,  1'b0, '0},
        '{8'h65,  1'b0, '0},
        '{CH_STX, 1'b0, '0},
        '{CH_ETX, 1'b0, '0},
        '{8'h30,  1'b0, '0},
        '{8'h34,  1'b1, '{K_BADSUM,     8'h00, 1'b1, CH_NAK, 1'b0}},
        '{CH_STX, 1'b0, '0},
        '{CH_ETX, 1'b0, '0},
        '{8'h67,  1'b0, '0},
        '{8'h33,  1'b1, '{K_UNREADABLE, 8'h00, 1'b0, 8'h00,  1'b0}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] kind;
    logic [7:0] payload_byte;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       too_long;

    // decoder state
    phase_t             rx_phase = PH_WAIT_STX;
    logic [7:0]         check_xor = 8'h00;
    logic [7:0]         first_char = 8'h00;
    logic [COUNT_W-1:0] rx_count = '0;

    result_t pending_results [$];
    int      mismatches = 0;
    int      bytes_sent = 0;
    int      results_seen = 0;
    int      sender_idle_pct = 0;
    int      receiver_idle_pct = 0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;
    int      cycle_count = 0;

    stx_etx_frame_receiver_xor_bcc dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .reply_valid  (reply_valid),
        .reply_byte   (reply_byte),
        .too_long     (too_long)
    );

    always #5 clk = ~clk;

    function automatic int hex_value_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    function automatic bit is_control(input logic [7:0] c);
        foreach (CONTROL_BYTES[i])
            if (c == CONTROL_BYTES[i])
                return 1'b1;
        return 1'b0;
    endfunction

    // Advances the decoder by one byte and returns the result beat it gives.
    function automatic result_t decode_rx_byte(input logic [7:0] b);
        result_t r;
        int      hi;
        int      lo;
        r = '{K_NONE, 8'h00, 1'b0, 8'h00, 1'b0};
        case (b)
            CH_ENQ:
            begin
                r.kind        = K_ENQ;
                r.reply_valid = 1'b1;
                r.reply_byte  = CH_SYN;
            end
            CH_ACK: r.kind = K_ACK;
            CH_NAK: r.kind = K_NAK;
            CH_SYN: r.kind = K_SYN;
            CH_DC3: r.kind = K_DC3;
            CH_EOT: r.kind = K_EOT;
            default: ;
        endcase
        r.too_long = (rx_count > PAYLOAD_LIMIT);
        if (r.kind != K_NONE)
            return r;

        case (rx_phase)
            PH_WAIT_STX:
            begin
                if (b == CH_STX)
                begin
                    rx_phase   = PH_PAYLOAD;
                    check_xor  = 8'h00;
                    first_char = 8'h00;
                    rx_count   = '0;
                end
                else
                    r.kind = K_STRAY;
                r.too_long = (rx_count > PAYLOAD_LIMIT);
            end
            PH_PAYLOAD:
            begin
                check_xor = check_xor ^ b;
                if (b == CH_ETX)
                    rx_phase = PH_SUM_HI;
                else
                begin
                    r.kind         = K_PAYLOAD;
                    r.payload_byte = b;
                    if (rx_count != COUNT_MAX)
                        rx_count = rx_count + 1'b1;
                end
                r.too_long = (rx_count > PAYLOAD_LIMIT);
            end
            PH_SUM_HI:
            begin
                first_char = b;
                rx_phase   = PH_SUM_LO;
            end
            default:
            begin
                // too_long still reports the frame just closed
                hi = hex_value_of(first_char);
                lo = hex_value_of(b);
                if (hi < 0 || lo < 0)
                    r.kind = K_UNREADABLE;
                else if ({hi[3:0], lo[3:0]} == check_xor)
                begin
                    r.kind        = K_GOOD;
                    r.reply_valid = 1'b1;
                    r.reply_byte  = CH_ACK;
                end
                else
                begin
                    r.kind        = K_BADSUM;
                    r.reply_valid = 1'b1;
                    r.reply_byte  = CH_NAK;
                end
                rx_phase = PH_WAIT_STX;
                rx_count = '0;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t, beat %0d: %s", $realtime, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input result_t typed_result = '0);
        result_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        predicted = decode_rx_byte(b);
        pending_results.push_back(typed ? typed_result : predicted);
        bytes_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        if ($urandom_range(0, 1) == 0)
            return 8'h61 + 8'(n) - 8'd10;
        return 8'h41 + 8'(n) - 8'd10;
    endfunction

    // One frame with random payload; mostly a good check, sometimes a wrong
    // or unreadable one.
    task automatic send_frame(input int len);
        logic [7:0] b;
        logic [7:0] bcc;
        logic [7:0] hi_c;
        logic [7:0] lo_c;
        int         sel;
        bcc = 8'h00;
        send_byte(CH_STX);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                send_byte(CONTROL_BYTES[$urandom_range(0, 5)]);
            // len counts real payload bytes
            b = 8'($urandom_range(0, 255));
            if (b == CH_ETX || is_control(b))
                b = 8'hFC;
            bcc = bcc ^ b;
            send_byte(b);
        end
        send_byte(CH_ETX);
        bcc  = bcc ^ CH_ETX;
        hi_c = hex_char(bcc[7:4]);
        lo_c = hex_char(bcc[3:0]);
        sel  = $urandom_range(0, 19);
        if (sel < 2)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (hex_value_of(b) >= 0 || is_control(b));
            if (sel == 0)
                hi_c = b;
            else
                lo_c = b;
        end
        else if (sel < 5)
            lo_c = hex_char(bcc[3:0] ^ 4'($urandom_range(1, 15)));
        send_byte(hi_c);
        send_byte(lo_c);
    endtask

    task automatic send_random_traffic(input int quota, input int long_len);
        int start;
        int sel;
        start = bytes_sent;
        if (long_len > 0)
            send_frame(long_len);
        while (bytes_sent - start < quota)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)));
            else if (sel == 1)
                send_byte(CONTROL_BYTES[$urandom_range(0, 5)]);
            else
                send_frame($urandom_range(0, 12));
        end
    endtask

    // result side: check, then choose the next stall
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected beat, kind %0d", kind));
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", kind, want.kind);
                check_field("payload_byte", payload_byte, want.payload_byte);
                check_field("reply_valid", reply_valid, want.reply_valid);
                check_field("reply_byte", reply_byte, want.reply_byte);
                check_field("too_long", too_long, want.too_long);
            end
            results_seen++;
        end
        // one long hold-off so the input side backs up
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle_pct   = 21;
        receiver_idle_pct = 54;
        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        send_random_traffic(380, $urandom_range(260, 280));
        drain_results();

        sender_idle_pct   = 54;
        receiver_idle_pct = 21;
        send_random_traffic(350, 0);
        drain_results();

        // boundary: the 256th payload byte is the first one flagged
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_random_traffic(350, PAYLOAD_LIMIT + 1);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ stx_etx_frame_receiver_xor_bcc.f @@
rtl/stxrx_pkg.sv
rtl/stxrx_frame.sv
rtl/stx_etx_frame_receiver_xor_bcc.sv
dv/tb.sv
